### design/gimli_pkg.sv
// Shared types, constants and the round function of the Gimli-384 permutation.
// Used by gimli_round_cell and gimli_permutation; depends on nothing else.
`timescale 1ns / 1ps

package gimli_pkg;

    localparam int WORD_W   = 32;
    localparam int NUM_WORDS = 12;
    localparam int STATE_W  = WORD_W * NUM_WORDS;
    localparam int MAX_ROUNDS = 24;
    localparam int RND_W    = 5;

    localparam logic [WORD_W-1:0] ROUND_CONST = 32'h9e37_7900;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [STATE_W-1:0] state_t;
    typedef logic [RND_W-1:0]   rnd_t;

    function automatic word_t rotl(input word_t v, input int n);
        rotl = (v << n) | (v >> (WORD_W - n));
    endfunction

    // One full round: SP-box on every column, then the swap and constant that
    // the round number calls for.
    function automatic state_t gimli_round(input state_t s, input rnd_t rnd);
        word_t w [NUM_WORDS];
        word_t x;
        word_t y;
        word_t z;
        word_t t;
        state_t res;
        for (int k = 0; k < NUM_WORDS; k++) begin
            w[k] = s[k*WORD_W +: WORD_W];
        end
        for (int j = 0; j < 4; j++) begin
            x = rotl(w[j], 24);
            y = rotl(w[4+j], 9);
            z = w[8+j];
            w[8+j] = x ^ (z << 1) ^ ((y & z) << 2);
            w[4+j] = y ^ x ^ ((x | z) << 1);
            w[j]   = z ^ y ^ ((x & y) << 3);
        end
        if (rnd[1:0] == 2'd0) begin
            t = w[0]; w[0] = w[1]; w[1] = t;
            t = w[2]; w[2] = w[3]; w[3] = t;
            w[0] = w[0] ^ ROUND_CONST ^ {{(WORD_W-RND_W){1'b0}}, rnd};
        end else if (rnd[1:0] == 2'd2) begin
            t = w[0]; w[0] = w[2]; w[2] = t;
            t = w[1]; w[1] = w[3]; w[3] = t;
        end
        for (int k = 0; k < NUM_WORDS; k++) begin
            res[k*WORD_W +: WORD_W] = w[k];
        end
        return res;
    endfunction

endpackage

### design/gimli_round_cell.sv
// One cell of the round chain: applies a single Gimli round and registers it.
// Depends on gimli_pkg for the state type and the round function.
`timescale 1ns / 1ps

module gimli_round_cell
    import gimli_pkg::*;
#(
    parameter int RND = MAX_ROUNDS
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  state_t in_state,
    output logic   out_valid,
    input  logic   out_ready,
    output state_t out_state
);

    logic   valid_reg;
    logic   valid_next;
    state_t state_reg;
    state_t state_next;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;
    assign state_next = gimli_round(in_state, rnd_t'(RND));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            state_reg <= state_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;

endmodule

### design/gimli_permutation.sv
// Top level of the Gimli-384 permutation: a chain of round cells.
// Depends on gimli_pkg and gimli_round_cell.
`timescale 1ns / 1ps
//
// The input channel (s_) takes one 384-bit state per transfer, word 0 in the
// lowest 32 bits of s_tdata. The result channel (m_) returns the permuted
// state in the same layout, one result transfer for every input transfer and
// in the same order.
// The permutation is a chain of ROUNDS cells, one round each, and every cell
// ends in a register. The result is offered from the last cell's register.
// A new state is taken in every cycle in which the chain is not stalled, so
// the throughput is one state per cycle while the receiver keeps up.
// Each cell is ready when it is empty or when its successor takes its content
// in the same cycle, so a stalled receiver only stops the chain once every
// cell holds a state; bubbles ahead of the stall are filled meanwhile.
// Reset (aresetn low at a clock edge) empties every cell; states in flight
// are discarded.
// The last cell's register is the result register and holds its state
// unchanged until m_tready is seen.

module gimli_permutation
    import gimli_pkg::*;
#(
    parameter int ROUNDS = MAX_ROUNDS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [STATE_W-1:0] s_tdata,  // in_word_0 .. in_word_11, 32 bits each
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [STATE_W-1:0] m_tdata   // out_word_0 .. out_word_11, 32 bits each
);

    logic   valid_chain [ROUNDS+1];
    logic   ready_chain [ROUNDS+1];
    state_t state_chain [ROUNDS+1];

    assign valid_chain[0] = s_tvalid;
    assign s_tready       = ready_chain[0];
    assign state_chain[0] = s_tdata;

    for (genvar i = 0; i < ROUNDS; i++) begin : g_cell
        gimli_round_cell #(
            .RND (ROUNDS - i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (valid_chain[i]),
            .in_ready  (ready_chain[i]),
            .in_state  (state_chain[i]),
            .out_valid (valid_chain[i+1]),
            .out_ready (ready_chain[i+1]),
            .out_state (state_chain[i+1])
        );
    end

    assign ready_chain[ROUNDS] = m_tready;
    assign m_tvalid            = valid_chain[ROUNDS];
    assign m_tdata             = state_chain[ROUNDS];

    // An empty result register implies the whole chain can move.
    assert property (@(posedge aclk) disable iff (!aresetn) !m_tvalid |-> s_tready)
        else $error("Input stalled although the result register is empty.");

    // A receiver that is ready lets the ready chain reach the input.
    assert property (@(posedge aclk) disable iff (!aresetn) m_tready |-> s_tready)
        else $error("Input stalled although the receiver is ready.");

    // A state that enters the first cell shows up there in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> valid_chain[1])
        else $error("Accepted transfer did not reach the first cell.");

endmodule
